>>> hw/rtl/rhwc_pkg.sv
// rhwc_pkg: shared types, constants and helper functions of the register hazard window counter
// no dependencies; imported by rhwc_cell and register_hazard_window_counter_top
`timescale 1ns / 1ps
`default_nettype none

package rhwc_pkg;

  localparam int REG_W     = 5;
  localparam int DEPTH_W   = 6;
  localparam int ADDR_W    = 64;
  localparam int CNT_W     = 32;
  localparam int KEY_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int REG_COUNT = 32;

  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 6'd32;
  localparam logic [ADDR_W-1:0]  START_RESET = 64'h0000_0000_8000_0000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START = 1'b1;

  typedef struct packed {
    logic [REG_W-1:0] rnum;
    logic             ww;
  } entry_t;

  // lookups of one step: [0] first read, [1] second read, [2] write
  typedef struct packed {
    logic [2:0]            act;
    logic [2:0][REG_W-1:0] rnum;
  } query_t;

  // sort key that follows the string order of the names X0, X1, X10, ..., X2, ...
  function automatic logic [KEY_W-1:0] name_key(input logic [REG_W-1:0] r);
    logic [1:0]       tens;
    logic [3:0]       units;
    logic [KEY_W-1:0] key;
    tens  = 2'd0;
    units = 4'd0;
    if (r < 5'd10) begin
      key = KEY_W'(r) * KEY_W'(11);
    end else begin
      if (r < 5'd20) begin
        tens  = 2'd1;
        units = 4'(r - 5'd10);
      end else if (r < 5'd30) begin
        tens  = 2'd2;
        units = 4'(r - 5'd20);
      end else begin
        tens  = 2'd3;
        units = 4'(r - 5'd30);
      end
      key = KEY_W'(tens) * KEY_W'(11) + KEY_W'(units) + KEY_W'(1);
    end
    return key;
  endfunction

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                               input logic [1:0] inc);
    logic [CNT_W:0] s;
    s = {1'b0, c} + (CNT_W + 1)'(inc);
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rhwc_cell.sv
// rhwc_cell: one window position; holds an entry, shifts it to the older neighbor
// and compares it against the three lookups of a step; uses rhwc_pkg
`timescale 1ns / 1ps
`default_nettype none

module rhwc_cell
  import rhwc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   shift,
  input  wire entry_t shift_in,
  output entry_t      shift_out,
  input  wire logic   compare,
  input  wire query_t query,
  input  wire logic   slot_valid,
  output logic [2:0]  hit
);

  entry_t     entry;
  logic [2:0] hit_next;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      hit_next[j] = slot_valid && query.act[j] && (query.rnum[j] == entry.rnum);
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      entry <= shift_in;
    end
    if (compare) begin
      hit <= hit_next;
    end
  end

  assign shift_out = entry;

endmodule

`default_nettype wire

>>> hw/rtl/rhwc_pick.sv
// rhwc_pick: picks the newest matching window position and reports its access kind
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module rhwc_pick #(
  parameter int N = 32
) (
  input  wire logic [N-1:0] hit,
  input  wire logic [N-1:0] ww,
  output logic              found,
  output logic              prev_w
);

  logic [N-1:0] first;

  // isolate lowest set bit, position 0 holds the newest entry
  assign first  = hit & ~(hit - N'(1));
  assign found  = |hit;
  assign prev_w = |(first & ww);

endmodule

`default_nettype wire

>>> hw/rtl/register_hazard_window_counter_top.sv
// register hazard window counter: each item passes lookup, pick and commit, then its distinct registers
// are appended in turn as the cell chain shifts one entry a step; a new item is accepted only
// once the previous one is committed and appended. The result sits in the counter registers
// until taken, while the next item is already accepted and looked up.
// rst (synchronous) clears counters, fill and active flag and loads the register defaults;
// no clearing pass, window entries beyond the fill count are never looked at
`timescale 1ns / 1ps
`default_nettype none

module register_hazard_window_counter_top
  import rhwc_pkg::*;
#(
  parameter int WINDOW_DEPTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]    cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [ADDR_W-1:0]    pc,
  input  wire logic                 read_a_valid,
  input  wire logic [REG_W-1:0]     read_a_reg,
  input  wire logic                 read_b_valid,
  input  wire logic [REG_W-1:0]     read_b_reg,
  input  wire logic                 write_valid,
  input  wire logic [REG_W-1:0]     write_reg,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      checking_active,
  output logic [CNT_W-1:0]          raw_total,
  output logic [CNT_W-1:0]          war_total,
  output logic [CNT_W-1:0]          waw_total,
  output logic [CNT_W-1:0]          rar_total
);

  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int LIM_W  = (FILL_W > DEPTH_W) ? FILL_W : DEPTH_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_RESOLVE,
    S_COMMIT,
    S_APPEND
  } state_t;

  typedef struct packed {
    logic             v;
    logic [REG_W-1:0] rnum;
    logic             ww;
  } slot_t;

  state_t             state;
  logic [DEPTH_W-1:0] depth_in_use;
  logic [ADDR_W-1:0]  start_address;
  logic [FILL_W-1:0]  fill;
  logic               active;
  logic               pend_active;
  query_t             query;
  slot_t [2:0]        slots;
  logic [1:0]         app_count;
  logic [1:0]         app_idx;
  logic [1:0]         raw_inc;
  logic [1:0]         rar_inc;
  logic               war_inc;
  logic               waw_inc;
  logic [CNT_W-1:0]   raw_cnt;
  logic [CNT_W-1:0]   war_cnt;
  logic [CNT_W-1:0]   waw_cnt;
  logic [CNT_W-1:0]   rar_cnt;

  // cell chain, position 0 is the newest entry
  entry_t                 cell_out [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] slot_valid;
  logic [2:0][WINDOW_DEPTH-1:0] hit_vec;
  logic [WINDOW_DEPTH-1:0] ww_vec;
  entry_t                 app_entry;

  logic [2:0] found;
  logic [2:0] prev_w;

  assign app_entry.rnum = slots[app_idx].rnum;
  assign app_entry.ww   = slots[app_idx].ww;

  for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
    entry_t     din;
    logic [2:0] hit;
    if (k == 0) begin : g_head
      assign din = app_entry;
    end else begin : g_link
      assign din = cell_out[k-1];
    end
    assign slot_valid[k] = fill > FILL_W'(k);
    rhwc_cell u_cell (
      .clk        (clk),
      .shift      (state == S_APPEND),
      .shift_in   (din),
      .shift_out  (cell_out[k]),
      .compare    (state == S_MATCH),
      .query      (query),
      .slot_valid (slot_valid[k]),
      .hit        (hit)
    );
    assign ww_vec[k] = cell_out[k].ww;
    for (genvar j = 0; j < 3; j++) begin : g_hit
      assign hit_vec[j][k] = hit[j];
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_pick
    rhwc_pick #(.N(WINDOW_DEPTH)) u_pick (
      .hit    (hit_vec[j]),
      .ww     (ww_vec),
      .found  (found[j]),
      .prev_w (prev_w[j])
    );
  end

  // append list: distinct registers, a write marks a read of the same register
  slot_t [2:0] raw_slots;
  slot_t [2:0] sorted;
  logic [1:0]  slot_count;

  function automatic logic slot_less(input slot_t x, input slot_t y);
    return x.v && (!y.v || (name_key(x.rnum) < name_key(y.rnum)));
  endfunction

  always_comb begin
    slot_t t;
    raw_slots[0].v    = query.act[0];
    raw_slots[0].rnum = query.rnum[0];
    raw_slots[0].ww   = query.act[2] && (query.rnum[0] == query.rnum[2]);
    raw_slots[1].v    = query.act[1] && !(query.act[0] && (query.rnum[1] == query.rnum[0]));
    raw_slots[1].rnum = query.rnum[1];
    raw_slots[1].ww   = query.act[2] && (query.rnum[1] == query.rnum[2]);
    raw_slots[2].v    = query.act[2]
                        && !(raw_slots[0].v && (query.rnum[0] == query.rnum[2]))
                        && !(raw_slots[1].v && (query.rnum[1] == query.rnum[2]));
    raw_slots[2].rnum = query.rnum[2];
    raw_slots[2].ww   = 1'b1;

    // three compare-exchange steps, empty slots sink to the end
    sorted = raw_slots;
    t      = raw_slots[0];
    if (slot_less(sorted[1], sorted[0])) begin
      t = sorted[0]; sorted[0] = sorted[1]; sorted[1] = t;
    end
    if (slot_less(sorted[2], sorted[1])) begin
      t = sorted[1]; sorted[1] = sorted[2]; sorted[2] = t;
    end
    if (slot_less(sorted[1], sorted[0])) begin
      t = sorted[0]; sorted[0] = sorted[1]; sorted[1] = t;
    end
    slot_count = 2'(raw_slots[0].v) + 2'(raw_slots[1].v) + 2'(raw_slots[2].v);
  end

  // window limit is depth_in_use capped at the cell count
  logic [LIM_W-1:0] limit;
  logic             grow;

  always_comb begin
    if (LIM_W'(depth_in_use) > LIM_W'(WINDOW_DEPTH)) begin
      limit = LIM_W'(WINDOW_DEPTH);
    end else begin
      limit = LIM_W'(depth_in_use);
    end
    grow = LIM_W'(fill) < limit;
  end

  logic             reg_ok_a;
  logic             reg_ok_b;
  logic             reg_ok_w;
  logic             active_next;
  logic             commit_go;

  assign reg_ok_a    = {2'b00, read_a_reg} < 7'(REG_COUNT);
  assign reg_ok_b    = {2'b00, read_b_reg} < 7'(REG_COUNT);
  assign reg_ok_w    = {2'b00, write_reg} < 7'(REG_COUNT);
  assign active_next = active || (pc >= start_address);
  // the counters are the result, so commit only once the previous one is taken
  assign commit_go   = (state == S_COMMIT) && !(out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      active        <= 1'b0;
      fill          <= '0;
      raw_cnt       <= '0;
      war_cnt       <= '0;
      waw_cnt       <= '0;
      rar_cnt       <= '0;
      depth_in_use  <= DEPTH_RESET;
      start_address <= START_RESET;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_DEPTH: depth_in_use  <= cfg_data[DEPTH_W-1:0];
          CFG_START: start_address <= cfg_data;
          default: ;
        endcase
      end
      if (commit_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            pend_active    <= active_next;
            query.act[0]   <= active_next && read_a_valid && reg_ok_a;
            query.act[1]   <= active_next && read_b_valid && reg_ok_b;
            query.act[2]   <= active_next && write_valid && reg_ok_w;
            query.rnum[0]  <= read_a_reg;
            query.rnum[1]  <= read_b_reg;
            query.rnum[2]  <= write_reg;
            state          <= S_MATCH;
          end
        end
        S_MATCH: begin
          state <= S_RESOLVE;
        end
        S_RESOLVE: begin
          slots     <= sorted;
          app_count <= slot_count;
          raw_inc   <= 2'(found[0] && prev_w[0]) + 2'(found[1] && prev_w[1]);
          rar_inc   <= 2'(found[0] && !prev_w[0]) + 2'(found[1] && !prev_w[1]);
          waw_inc   <= found[2] && prev_w[2];
          war_inc   <= found[2] && !prev_w[2];
          state     <= S_COMMIT;
        end
        S_COMMIT: begin
          if (commit_go) begin
            active    <= pend_active;
            raw_cnt   <= sat_add(raw_cnt, raw_inc);
            rar_cnt   <= sat_add(rar_cnt, rar_inc);
            waw_cnt   <= sat_add(waw_cnt, {1'b0, waw_inc});
            war_cnt   <= sat_add(war_cnt, {1'b0, war_inc});
            app_idx   <= 2'd0;
            state     <= (app_count != 2'd0) ? S_APPEND : S_IDLE;
          end
        end
        S_APPEND: begin
          if (grow) begin
            fill <= fill + FILL_W'(1);
          end
          app_idx <= app_idx + 2'd1;
          if (app_idx == app_count - 2'd1) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall        = (state != S_IDLE);
  assign checking_active = active;
  assign raw_total       = raw_cnt;
  assign war_total       = war_cnt;
  assign waw_total       = waw_cnt;
  assign rar_total       = rar_cnt;

`ifndef SYNTHESIS
  a_fill_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> fill >= $past(fill))
    else $error("window fill went down");

  a_fill_only_on_append: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (fill != $past(fill)) |-> $past(state == S_APPEND))
    else $error("window fill changed outside of an append");

  a_counter_moves_with_result: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (raw_cnt != $past(raw_cnt)) |-> out_valid && $past(state == S_COMMIT))
    else $error("raw counter changed without a new result");

  a_counter_no_wrap: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> rar_cnt >= $past(rar_cnt))
    else $error("rar counter wrapped");

  a_result_from_commit: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $rose(out_valid) |-> $past(state == S_COMMIT))
    else $error("result raised outside of commit");
`endif

endmodule

`default_nettype wire
